// File: design/ordered_set_successor_engine_unit_macros.svh
// Assertion macros shared by the ordered set engine RTL.
`ifndef ORDERED_SET_SUCCESSOR_ENGINE_UNIT_MACROS_SVH
`define ORDERED_SET_SUCCESSOR_ENGINE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OSSE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered set engine: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define OSSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered set engine: next-cycle check failed");

`endif

// File: design/osse_pkg.sv
// Package with the types and constants of the ordered set engine.
package osse_pkg;

    localparam int KEY_BITS = 32;
    localparam int CAPACITY = 64;

    typedef logic signed [KEY_BITS-1:0] key_t;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_EXISTS = 3'd2;
    localparam logic [2:0] OP_NEXT   = 3'd3;
    localparam logic [2:0] OP_PREV   = 3'd4;

    typedef struct packed {
        logic [2:0] operation;
        key_t       key;
    } req_t;

    typedef struct packed {
        logic found;
        key_t neighbor_key;
        logic status;
    } rsp_t;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_e;

    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } flags_t;

    typedef struct packed {
        logic hit;
        logic nxt;
        logic prv;
    } sel_t;

    typedef struct packed {
        logic cmp_en;
        logic ins_en;
        logic del_en;
    } cell_ctl_t;

endpackage

// File: design/osse_cell.sv
// One slot of the sorted key row: compare against the request key and shift.
module osse_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 7
) (
    input  logic               clk,
    input  osse_pkg::cell_ctl_t ctl,
    input  osse_pkg::key_t     key,
    input  logic [CW-1:0]      count,
    input  osse_pkg::flags_t   left_flags,
    input  osse_pkg::flags_t   right_flags,
    input  osse_pkg::key_t     left_key,
    input  osse_pkg::key_t     right_key,
    output osse_pkg::flags_t   flags,
    output osse_pkg::key_t     key_q,
    output osse_pkg::sel_t     sel
);

    osse_pkg::flags_t flags_reg;
    osse_pkg::flags_t flags_next;
    osse_pkg::key_t   key_reg;
    osse_pkg::key_t   key_next;
    logic             valid;

    always_comb
    begin
        valid         = CW'(INDEX) < count;
        flags_next.lt = valid && (key_reg < key);
        flags_next.eq = valid && (key_reg == key);
        flags_next.gt = valid && (key_reg > key);

        key_next = key_reg;
        if (ctl.ins_en && !flags_reg.lt)
        begin
            key_next = left_flags.lt ? key : left_key;
        end
        else if (ctl.del_en && !flags_reg.lt)
        begin
            key_next = right_key;
        end

        sel.hit = flags_reg.eq;
        sel.nxt = flags_reg.gt && !left_flags.gt;
        sel.prv = flags_reg.lt && !right_flags.lt;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cmp_en)
        begin
            flags_reg <= flags_next;
        end
        if (ctl.ins_en || ctl.del_en)
        begin
            key_reg <= key_next;
        end
    end

    assign flags = flags_reg;
    assign key_q = key_reg;

endmodule

// File: design/ordered_set_successor_engine_unit.sv
// Top level of the ordered set engine: sorted row of key cells and request control.
//
// The block keeps up to CAPACITY distinct signed keys in ascending order in a row
// of cells. A request on the req channel (valid/ready) carries an operation and a
// key: insert, delete, exists, next greater or previous smaller. Every request
// gives exactly one response on the rsp channel (valid/ready) with found,
// neighbor_key and status (status is 1 when an insert hits a full table).
// A request has a compare step and an update step. In the accept cycle every cell
// compares its key with the request key in parallel; in the update step the row
// shifts right for an insert or left for a delete and the response is loaded into
// the output register. No new request is accepted until that update step is done.
// A new request is accepted while an earlier response still waits in the output
// register; if the receiver stalls, the second step holds until that register
// frees up, and no state changes in the meantime.
// Reset empties the set at once; stored keys need no clearing.
`include "ordered_set_successor_engine_unit_macros.svh"

module ordered_set_successor_engine_unit #(
    parameter int CAPACITY = osse_pkg::CAPACITY
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  osse_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output osse_pkg::rsp_t rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    osse_pkg::state_e    state_reg;
    osse_pkg::state_e    state_next;
    osse_pkg::req_t      req_reg;
    osse_pkg::rsp_t      rsp_reg;
    osse_pkg::rsp_t      rsp_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;

    osse_pkg::cell_ctl_t ctl;
    osse_pkg::key_t      key_bus;
    osse_pkg::flags_t    flags   [CAPACITY];
    osse_pkg::key_t      keys    [CAPACITY];
    osse_pkg::sel_t      sels    [CAPACITY];
    logic [CAPACITY-1:0] nxt_vec;
    logic [CAPACITY-1:0] prv_vec;
    logic                req_fire;
    logic                upd_fire;
    logic                present;
    logic                full;
    logic                nxt_any;
    logic                prv_any;
    osse_pkg::key_t      nxt_key;
    osse_pkg::key_t      prv_key;

    assign req_fire = req_valid && req_ready;
    assign upd_fire = (state_reg == osse_pkg::ST_UPDATE) && (!rsp_valid_reg || rsp_ready);
    assign full     = count_reg == CW'(CAPACITY);
    assign key_bus  = (state_reg == osse_pkg::ST_IDLE) ? req.key : req_reg.key;

    always_comb
    begin
        present = 1'b0;
        nxt_key = '0;
        prv_key = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            present    = present | sels[i].hit;
            nxt_vec[i] = sels[i].nxt;
            prv_vec[i] = sels[i].prv;
            nxt_key    = nxt_key | (sels[i].nxt ? keys[i] : '0);
            prv_key    = prv_key | (sels[i].prv ? keys[i] : '0);
        end
        nxt_any = |nxt_vec;
        prv_any = |prv_vec;
    end

    always_comb
    begin
        ctl.cmp_en = req_fire;
        ctl.ins_en = 1'b0;
        ctl.del_en = 1'b0;
        count_next = count_reg;
        rsp_next   = rsp_reg;
        if (upd_fire)
        begin
            rsp_next = '0;
            case (req_reg.operation)
                osse_pkg::OP_INSERT:
                begin
                    if (!present)
                    begin
                        if (full)
                        begin
                            rsp_next.status = 1'b1;
                        end
                        else
                        begin
                            ctl.ins_en = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                end
                osse_pkg::OP_DELETE:
                begin
                    if (present)
                    begin
                        ctl.del_en = 1'b1;
                        count_next = count_reg - CW'(1);
                    end
                end
                osse_pkg::OP_EXISTS:
                begin
                    rsp_next.found = present;
                end
                osse_pkg::OP_NEXT:
                begin
                    rsp_next.found        = nxt_any;
                    rsp_next.neighbor_key = nxt_key;
                end
                osse_pkg::OP_PREV:
                begin
                    rsp_next.found        = prv_any;
                    rsp_next.neighbor_key = prv_key;
                end
                default:
                begin
                    rsp_next = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        case (state_reg)
            osse_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    state_next = osse_pkg::ST_UPDATE;
                end
            end
            osse_pkg::ST_UPDATE:
            begin
                if (upd_fire)
                begin
                    state_next = osse_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = osse_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (upd_fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= osse_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        osse_pkg::flags_t lf;
        osse_pkg::flags_t rf;
        osse_pkg::key_t   lk;
        osse_pkg::key_t   rk;

        if (g == 0)
        begin : g_first
            assign lf = '{lt: 1'b1, eq: 1'b0, gt: 1'b0};
            assign lk = keys[g];
        end
        else
        begin : g_mid_l
            assign lf = flags[g-1];
            assign lk = keys[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign rf = '{lt: 1'b0, eq: 1'b0, gt: 1'b0};
            assign rk = keys[g];
        end
        else
        begin : g_mid_r
            assign rf = flags[g+1];
            assign rk = keys[g+1];
        end

        osse_cell #(
            .INDEX (g),
            .CW    (CW)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .key         (key_bus),
            .count       (count_reg),
            .left_flags  (lf),
            .right_flags (rf),
            .left_key    (lk),
            .right_key   (rk),
            .flags       (flags[g]),
            .key_q       (keys[g]),
            .sel         (sels[g])
        );
    end

    `OSSE_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(CAPACITY))
    `OSSE_ASSERT_NEXT(a_accept_update, clk, rst_n, req_fire, state_reg == osse_pkg::ST_UPDATE)
    `OSSE_ASSERT_NOW(a_full_status, clk, rst_n, rsp_valid && rsp.status, full)
    `OSSE_ASSERT_NOW(a_single_neighbor, clk, rst_n, state_reg == osse_pkg::ST_UPDATE,
        $onehot0(nxt_vec) && $onehot0(prv_vec))

endmodule
